FILE: rtl/core/pwf_pkg.sv
`default_nettype none

package pwf_pkg;

  // Output position fields keep their low six bits.
  localparam int POS_W = 6;

  // Widths of the configuration registers.
  localparam int SIDE_CFG_W   = 7;
  localparam int WIN_CFG_W    = 4;
  localparam int STRIDE_CFG_W = 4;

  // Configuration write channel.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_SIDE  = 3'd0,
    REG_WINDOW_SIZE = 3'd1,
    REG_STRIDE      = 3'd2,
    REG_POOL_MODE   = 3'd3,
    REG_ACTIVATION  = 3'd4
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [SIDE_CFG_W-1:0]   RST_PLANE_SIDE  = 7'd8;
  localparam logic [WIN_CFG_W-1:0]    RST_WINDOW_SIZE = 4'd2;
  localparam logic [STRIDE_CFG_W-1:0] RST_STRIDE      = 4'd2;

  // Pool modes.
  localparam logic MODE_MAX  = 1'b0;
  localparam logic MODE_MEAN = 1'b1;

  // What the position tracker reports for the sample at the input.
  typedef struct packed {
    logic             hit;
    logic             eop;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
  } win_info_t;

endpackage

`default_nettype wire

FILE: rtl/core/pwf_ifs.sv
`default_nettype none

// Sample channel.
interface pwf_in_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result channel.
interface pwf_out_if #(parameter int DATA_WIDTH = 16);
  import pwf_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pooled_value;
  logic signed [DATA_WIDTH-1:0] mask_value;
  logic [POS_W-1:0]             out_row;
  logic [POS_W-1:0]             out_col;
  logic [POS_W-1:0]             arg_row;
  logic [POS_W-1:0]             arg_col;
  logic                         end_of_plane;

  modport source (output valid, output pooled_value, output mask_value, output out_row,
                  output out_col, output arg_row, output arg_col, output end_of_plane,
                  input ready);
  modport sink   (input valid, input pooled_value, input mask_value, input out_row,
                  input out_col, input arg_row, input arg_col, input end_of_plane,
                  output ready);
endinterface

// Configuration write channel.
interface pwf_cfg_if;
  import pwf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pwf_ram.sv
`default_nettype none

module pwf_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 512,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/pwf_divider.sv
`default_nettype none

module pwf_divider #(
  parameter int  NUM_W = 22,
  parameter int  DEN_W = 8,
  localparam int CNT_W = $clog2(NUM_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] acc_r;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // Restoring step: bring down the next numerator bit and try to subtract.
  always_comb begin
    rem_sh  = {rem_r, acc_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
  end

  // Control: one quotient bit per cycle, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      acc_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      acc_r <= {acc_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = acc_r;

endmodule

`default_nettype wire

FILE: rtl/core/pwf_scan.sv
`default_nettype none

module pwf_scan #(
  parameter int  MAX_SIDE   = 64,
  parameter int  MAX_WINDOW = 8,
  localparam int PW  = $clog2(MAX_SIDE + 1),
  localparam int WW  = $clog2(MAX_WINDOW + 1),
  localparam int RW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int CLW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                restart,
  input  wire logic                                advance,
  input  wire logic [PW-1:0]                       side,
  input  wire logic [WW-1:0]                       win,
  input  wire logic [pwf_pkg::STRIDE_CFG_W-1:0]    stride,
  output pwf_pkg::win_info_t                       info,
  output logic      [PW-1:0]                       y0,
  output logic      [PW-1:0]                       x0,
  output logic      [RW-1:0]                       ring0,
  output logic      [RW-1:0]                       cur_ring,
  output logic      [CLW-1:0]                      cur_col
);
  import pwf_pkg::*;

  localparam int MW0 = (PW > WW) ? PW : WW;
  localparam int XW  = ((MW0 > STRIDE_CFG_W) ? MW0 : STRIDE_CFG_W) + 1;

  logic [PW-1:0]           r_r, c_r, r_nxt, c_nxt;
  logic [RW-1:0]           ring_r, ring_nxt;
  logic [STRIDE_CFG_W-1:0] ym_r, xm_r, ym_nxt, xm_nxt;
  logic [PW-1:0]           yq_r, xq_r, yq_nxt, xq_nxt;

  logic [XW-1:0] side_x, win_x, st_x, r_x, c_x, y0_x, x0_x, lim_x;
  logic [XW-1:0] ring_x, wm1_x, ring0_x;
  logic          fit, row_ok, col_ok, c_wrap, r_wrap;

  // Window position of the sample at the input.
  always_comb begin
    side_x = XW'(side);
    win_x  = XW'(win);
    st_x   = XW'(stride);
    r_x    = XW'(r_r);
    c_x    = XW'(c_r);
    fit    = win_x <= side_x;
    row_ok = r_x + XW'(1) >= win_x;
    col_ok = c_x + XW'(1) >= win_x;
    y0_x   = r_x + XW'(1) - win_x;
    x0_x   = c_x + XW'(1) - win_x;
    lim_x  = side_x - win_x;

    info.hit     = fit && row_ok && col_ok && (ym_r == '0) && (xm_r == '0);
    info.eop     = (y0_x + st_x > lim_x) && (x0_x + st_x > lim_x);
    info.out_row = POS_W'(yq_r);
    info.out_col = POS_W'(xq_r);

    // Store row that holds the window's top row.
    ring_x  = XW'(ring_r);
    wm1_x   = win_x - XW'(1);
    ring0_x = (ring_x >= wm1_x) ? ring_x - wm1_x : ring_x + XW'(MAX_WINDOW) - wm1_x;
  end

  assign y0       = PW'(y0_x);
  assign x0       = PW'(x0_x);
  assign ring0    = RW'(ring0_x);
  assign cur_ring = ring_r;
  assign cur_col  = CLW'(c_r);

  // Raster counters and stride phases for the next sample.
  always_comb begin
    c_wrap   = c_x + XW'(1) >= side_x;
    r_wrap   = r_x + XW'(1) >= side_x;
    r_nxt    = r_r;
    c_nxt    = c_wrap ? '0 : PW'(c_x + XW'(1));
    ring_nxt = ring_r;
    ym_nxt   = ym_r;
    yq_nxt   = yq_r;
    xm_nxt   = xm_r;
    xq_nxt   = xq_r;

    if (XW'(c_nxt) < win_x) begin
      xm_nxt = '0;
      xq_nxt = '0;
    end else if (xm_r + STRIDE_CFG_W'(1) == stride) begin
      xm_nxt = '0;
      xq_nxt = xq_r + PW'(1);
    end else begin
      xm_nxt = xm_r + STRIDE_CFG_W'(1);
    end

    if (c_wrap) begin
      r_nxt = r_wrap ? '0 : PW'(r_x + XW'(1));
      if (r_wrap || ring_r == RW'(MAX_WINDOW - 1)) begin
        ring_nxt = '0;
      end else begin
        ring_nxt = ring_r + RW'(1);
      end
      if (XW'(r_nxt) < win_x) begin
        ym_nxt = '0;
        yq_nxt = '0;
      end else if (ym_r + STRIDE_CFG_W'(1) == stride) begin
        ym_nxt = '0;
        yq_nxt = yq_r + PW'(1);
      end else begin
        ym_nxt = ym_r + STRIDE_CFG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      r_r    <= '0;
      c_r    <= '0;
      ring_r <= '0;
      ym_r   <= '0;
      yq_r   <= '0;
      xm_r   <= '0;
      xq_r   <= '0;
    end else if (advance) begin
      r_r    <= r_nxt;
      c_r    <= c_nxt;
      ring_r <= ring_nxt;
      ym_r   <= ym_nxt;
      yq_r   <= yq_nxt;
      xm_r   <= xm_nxt;
      xq_r   <= xq_nxt;
    end
  end

  // The column counter never reaches the plane side.
  a_col_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    c_r < side) else $error("column counter outside the plane");

  // The column stride phase stays below the stride.
  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    xm_r < ((stride == '0) ? STRIDE_CFG_W'(1) : stride))
    else $error("column stride phase out of range");

  // The store row follows the plane row: row zero always lands in store row zero.
  a_ring_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    (r_r == '0) |-> (ring_r == '0)) else $error("store row lost track of plane row");

endmodule

`default_nettype wire

FILE: rtl/core/pooling_window_forward_unit.sv
`default_nettype none

// Channel  Dir  Handshake        Payload
// in_ch    in   valid / ready    sample
// out_ch   out  valid / ready    pooled_value, mask_value, out_row, out_col,
//                                arg_row, arg_col, end_of_plane
// cfg_ch   in   valid / ready    reg_index, wr_data (ready is always high)
//
// An item that closes no window leaves in_ch.ready high. An item that closes a
// window of side w is walked through the line store one element per cycle by a
// single add/compare unit; mean pooling then adds the iterative divider, one
// quotient bit per cycle, whose done flag follows the last bit.
// in_ch.ready is low while a window is being worked on and while a result waits
// for a full output register. Reset is synchronous, active low; any write to a
// known register also restarts the plane. The line store needs no clearing after reset.
module pooling_window_forward_unit #(
  parameter int MAX_SIDE   = 64,
  parameter int MAX_WINDOW = 8,
  parameter int DATA_WIDTH = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  pwf_in_if.sink   in_ch,
  pwf_out_if.source out_ch,
  pwf_cfg_if.sink  cfg_ch
);
  import pwf_pkg::*;

  localparam int PW    = $clog2(MAX_SIDE + 1);
  localparam int WW    = $clog2(MAX_WINDOW + 1);
  localparam int RW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CLW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH = MAX_WINDOW * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0;
  localparam int SUMW  = DATA_WIDTH + 2 * LW;
  localparam int NDW   = 2 * WW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_FIN,
    S_DIV,
    S_OUT
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SIDE_CFG_W-1:0]   plane_side_r;
  logic [WIN_CFG_W-1:0]    window_size_r;
  logic [STRIDE_CFG_W-1:0] stride_r;
  logic                    pool_mode_r;
  logic                    activation_r;
  logic                    cfg_wr;
  logic                    cfg_known;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    unique case (cfg_reg_t'(cfg_ch.reg_index))
      REG_PLANE_SIDE, REG_WINDOW_SIZE, REG_STRIDE,
      REG_POOL_MODE, REG_ACTIVATION: cfg_known = 1'b1;
      default:                       cfg_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_side_r  <= RST_PLANE_SIDE;
      window_size_r <= RST_WINDOW_SIZE;
      stride_r      <= RST_STRIDE;
      pool_mode_r   <= MODE_MAX;
      activation_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_ch.reg_index))
        REG_PLANE_SIDE:  plane_side_r  <= cfg_ch.wr_data[SIDE_CFG_W-1:0];
        REG_WINDOW_SIZE: window_size_r <= cfg_ch.wr_data[WIN_CFG_W-1:0];
        REG_STRIDE:      stride_r      <= cfg_ch.wr_data[STRIDE_CFG_W-1:0];
        REG_POOL_MODE:   pool_mode_r   <= cfg_ch.wr_data[0];
        REG_ACTIVATION:  activation_r  <= cfg_ch.wr_data[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero reads as one, oversize clamps to the maximum.
  logic [PW-1:0]           side_eff;
  logic [WW-1:0]           win_eff;
  logic [WW-1:0]           win_last;
  logic [STRIDE_CFG_W-1:0] stride_eff;

  always_comb begin
    if (plane_side_r == '0) begin
      side_eff = PW'(1);
    end else if (int'(plane_side_r) > MAX_SIDE) begin
      side_eff = PW'(MAX_SIDE);
    end else begin
      side_eff = PW'(plane_side_r);
    end
    if (window_size_r == '0) begin
      win_eff = WW'(1);
    end else if (int'(window_size_r) > MAX_WINDOW) begin
      win_eff = WW'(MAX_WINDOW);
    end else begin
      win_eff = WW'(window_size_r);
    end
    win_last   = win_eff - WW'(1);
    stride_eff = (stride_r == '0) ? STRIDE_CFG_W'(1) : stride_r;
  end

  // ---------------------------------------------------------------------------
  // Position tracking and line store
  // ---------------------------------------------------------------------------
  state_t    state_r, state_nxt;
  logic      in_acc;
  win_info_t info;
  logic [PW-1:0]  y0, x0;
  logic [RW-1:0]  ring0, cur_ring;
  logic [CLW-1:0] cur_col;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  pwf_scan #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_wr && cfg_known),
    .advance  (in_acc),
    .side     (side_eff),
    .win      (win_eff),
    .stride   (stride_eff),
    .info     (info),
    .y0       (y0),
    .x0       (x0),
    .ring0    (ring0),
    .cur_ring (cur_ring),
    .cur_col  (cur_col)
  );

  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  // Window walk registers.
  logic [PW-1:0]    y0_r, x0_r;
  logic [RW-1:0]    wring_r;
  logic [WW-1:0]    wy_r, wx_r;
  logic             eop_r;
  logic [POS_W-1:0] orow_r, ocol_r;
  logic             last_issue;
  logic [CLW-1:0]   rd_col;

  assign wr_addr    = AW'(cur_ring) * AW'(MAX_SIDE) + AW'(cur_col);
  assign rd_col     = CLW'(x0_r + PW'(wx_r));
  assign rd_addr    = AW'(wring_r) * AW'(MAX_SIDE) + AW'(rd_col);
  assign last_issue = (wx_r == win_last) && (wy_r == win_last);

  pwf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wr_addr),
    .wdata (in_ch.sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Latch the window on a hit, then step through it in raster order.
  always_ff @(posedge clk) begin
    if (in_acc && info.hit) begin
      y0_r    <= y0;
      x0_r    <= x0;
      wring_r <= ring0;
      eop_r   <= info.eop;
      orow_r  <= info.out_row;
      ocol_r  <= info.out_col;
      wy_r    <= '0;
      wx_r    <= '0;
    end else if (state_r == S_WALK) begin
      if (wx_r == win_last) begin
        wx_r <= '0;
        wy_r <= wy_r + WW'(1);
        if (wring_r == RW'(MAX_WINDOW - 1)) begin
          wring_r <= '0;
        end else begin
          wring_r <= wring_r + RW'(1);
        end
      end else begin
        wx_r <= wx_r + WW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared add/compare unit: one window element per cycle
  // ---------------------------------------------------------------------------
  logic                         rd_vld_r;
  logic                         first_r;
  logic [POS_W-1:0]             pos_row_r, pos_col_r;
  logic signed [DATA_WIDTH-1:0] elem;
  logic signed [SUMW-1:0]       sum_r;
  logic signed [DATA_WIDTH-1:0] best_r;
  logic [POS_W-1:0]             arg_row_r, arg_col_r;

  assign elem = rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      first_r  <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_WALK);
      if (in_acc && info.hit) begin
        first_r <= 1'b1;
      end else if (rd_vld_r) begin
        first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_row_r <= POS_W'(y0_r + PW'(wy_r));
    pos_col_r <= POS_W'(x0_r + PW'(wx_r));
    if (rd_vld_r) begin
      if (first_r) begin
        sum_r     <= SUMW'(elem);
        best_r    <= elem;
        arg_row_r <= pos_row_r;
        arg_col_r <= pos_col_r;
      end else begin
        sum_r <= sum_r + SUMW'(elem);
        // Strictly greater: a tie keeps the earlier element.
        if (elem > best_r) begin
          best_r    <= elem;
          arg_row_r <= pos_row_r;
          arg_col_r <= pos_col_r;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Mean: magnitude divided by w*w, sign put back (truncates toward zero)
  // ---------------------------------------------------------------------------
  logic                  div_start, div_done;
  logic [SUMW-1:0]       sum_mag;
  logic [NDW-1:0]        div_den;
  logic [SUMW-1:0]       quot;
  logic                  neg_r;
  logic [DATA_WIDTH-1:0] mean;

  assign div_start = (state_r == S_FIN) && (pool_mode_r == MODE_MEAN);
  assign sum_mag   = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
  assign div_den   = NDW'(win_eff) * NDW'(win_eff);

  pwf_divider #(
    .NUM_W (SUMW),
    .DEN_W (NDW)
  ) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_mag),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= sum_r[SUMW-1];
    end
  end

  assign mean = neg_r ? -DATA_WIDTH'(quot) : DATA_WIDTH'(quot);

  // ---------------------------------------------------------------------------
  // Result formation
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] pooled, pre_act, mask;
  logic [POS_W-1:0]      arg_row, arg_col;

  always_comb begin
    if (pool_mode_r == MODE_MEAN) begin
      pre_act = mean;
      mask    = mean;
      arg_row = '0;
      arg_col = '0;
    end else begin
      pre_act = best_r;
      mask    = '0;
      arg_row = arg_row_r;
      arg_col = arg_col_r;
    end
    pooled = (activation_r && pre_act[DATA_WIDTH-1]) ? '0 : pre_act;
  end

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  logic                  out_vld_r, out_vld_nxt, load;
  logic [DATA_WIDTH-1:0] o_pooled_r, o_mask_r;
  logic [POS_W-1:0]      o_row_r, o_col_r, o_arow_r, o_acol_r;
  logic                  o_eop_r;

  assign load = (state_r == S_OUT) && (!out_vld_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && info.hit) state_nxt = S_WALK;
      S_WALK:  if (last_issue) state_nxt = S_FLUSH;
      S_FLUSH: state_nxt = S_FIN;
      S_FIN:   state_nxt = (pool_mode_r == MODE_MEAN) ? S_DIV : S_OUT;
      S_DIV:   if (div_done) state_nxt = S_OUT;
      S_OUT:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (load) begin
      o_pooled_r <= pooled;
      o_mask_r   <= mask;
      o_row_r    <= orow_r;
      o_col_r    <= ocol_r;
      o_arow_r   <= arg_row;
      o_acol_r   <= arg_col;
      o_eop_r    <= eop_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.pooled_value = o_pooled_r;
  assign out_ch.mask_value   = o_mask_r;
  assign out_ch.out_row      = o_row_r;
  assign out_ch.out_col      = o_col_r;
  assign out_ch.arg_row      = o_arow_r;
  assign out_ch.arg_col      = o_acol_r;
  assign out_ch.end_of_plane = o_eop_r;

  // Every store read has been folded in before the result is formed.
  a_reads_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !rd_vld_r) else $error("store read still in flight");

  // The divider only finishes while the sequencer waits for it.
  a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV)) else $error("divider finished out of step");

  // A new result shows up only after the sequencer handed it over.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_OUT)) else $error("result without a window");

endmodule

`default_nettype wire

FILE: bench/pooling_window_forward_unit_test.sv
`default_nettype none

module pooling_window_forward_unit_test;
  import pwf_pkg::*;

  localparam int MAX_SIDE      = 64;
  localparam int MAX_WINDOW    = 8;
  localparam int DATA_WIDTH    = 16;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int QUIET_TAIL    = 200;
  localparam int SETTLE_CYCLES = 120;
  localparam int DRAIN_CYCLES  = 150;
  localparam int STALL_LIMIT   = 5000;

  localparam logic ACT_NONE = 1'b0;
  localparam logic ACT_RELU = 1'b1;
  // An index past the last register: the write must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  // One entry of the stimulus feed: a register write or a sample.
  typedef struct {
    bit                          is_cfg;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_DATA_W-1:0]       data;
    logic signed [DATA_WIDTH-1:0] sample;
  } feed_entry_t;

  // One pooled result as the block should give it.
  typedef struct {
    logic signed [DATA_WIDTH-1:0] pooled;
    logic signed [DATA_WIDTH-1:0] mask;
    logic [POS_W-1:0]             orow;
    logic [POS_W-1:0]             ocol;
    logic [POS_W-1:0]             arow;
    logic [POS_W-1:0]             acol;
    logic                         eop;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pwf_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_ch();
  pwf_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch();
  pwf_cfg_if cfg_ch();

  pooling_window_forward_unit #(
    .MAX_SIDE(MAX_SIDE),
    .MAX_WINDOW(MAX_WINDOW),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  feed_entry_t  sample_feed[$];
  pool_result_t pending_windows[$];
  int           error_count = 0;
  int           random_items = 0;

  // Shadow of the block: configuration, raster position and line store.
  logic [SIDE_CFG_W-1:0]        cfg_side = RST_PLANE_SIDE;
  logic [WIN_CFG_W-1:0]         cfg_win = RST_WINDOW_SIZE;
  logic [STRIDE_CFG_W-1:0]      cfg_stride = RST_STRIDE;
  logic                         cfg_mode = MODE_MAX;
  logic                         cfg_relu = ACT_NONE;
  int                           row_pos = 0;
  int                           col_pos = 0;
  logic signed [DATA_WIDTH-1:0] line_store [0:MAX_WINDOW*MAX_SIDE-1];

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int side_in_use(input logic [SIDE_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic int window_in_use(input logic [WIN_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WINDOW) return MAX_WINDOW;
    return v;
  endfunction

  function automatic int store_slot(input int r, input int c);
    return (r % MAX_WINDOW) * MAX_SIDE + c;
  endfunction

  // A write to a known register takes its low bits and restarts the plane.
  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PLANE_SIDE:  cfg_side = data;
      REG_WINDOW_SIZE: cfg_win = data[WIN_CFG_W-1:0];
      REG_STRIDE:      cfg_stride = data[STRIDE_CFG_W-1:0];
      REG_POOL_MODE:   cfg_mode = data[0];
      REG_ACTIVATION:  cfg_relu = data[0];
      default:         return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endtask

  // Store one sample and, if it closes a window on the stride grid, queue its result.
  task automatic predict_pooled_window(input logic signed [DATA_WIDTH-1:0] smp);
    int side, ws, st, r, c, y0, x0, y, x, last_origin;
    int best, sum, elem, ar, ac, val, mean;
    pool_result_t res;
    side = side_in_use(cfg_side);
    ws = window_in_use(cfg_win);
    st = (cfg_stride == 0) ? 1 : int'(cfg_stride);
    r = row_pos;
    c = col_pos;
    if (r >= side) r = 0;
    if (c >= side) c = 0;
    line_store[store_slot(r, c)] = smp;
    if (ws <= side && r + 1 >= ws && c + 1 >= ws) begin
      y0 = r + 1 - ws;
      x0 = c + 1 - ws;
      if (y0 % st == 0 && x0 % st == 0) begin
        last_origin = ((side - ws) / st) * st;
        best = line_store[store_slot(y0, x0)];
        sum = 0;
        mean = 0;
        ar = y0;
        ac = x0;
        // Strictly greater keeps the first maximum in raster order.
        for (y = y0; y <= r; y++) begin
          for (x = x0; x <= c; x++) begin
            elem = line_store[store_slot(y, x)];
            sum += elem;
            if (elem > best) begin
              best = elem;
              ar = y;
              ac = x;
            end
          end
        end
        if (cfg_mode == MODE_MEAN) begin
          mean = sum / (ws * ws);
          val = mean;
          ar = 0;
          ac = 0;
        end else begin
          val = best;
        end
        if (cfg_relu == ACT_RELU && val < 0) val = 0;
        res.pooled = val[DATA_WIDTH-1:0];
        res.mask = mean[DATA_WIDTH-1:0];
        res.orow = POS_W'(y0 / st);
        res.ocol = POS_W'(x0 / st);
        res.arow = POS_W'(ar);
        res.acol = POS_W'(ac);
        res.eop = (y0 == last_origin && x0 == last_origin);
        pending_windows.push_back(res);
      end
    end
    c++;
    if (c >= side) begin
      c = 0;
      r++;
      if (r >= side) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // Stimulus building.
  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    feed_entry_t e;
    e.is_cfg = 1'b1;
    e.idx = idx;
    e.data = data;
    e.sample = '0;
    sample_feed.push_back(e);
  endtask

  // Writes every register; bits above each register's width are random.
  task automatic queue_setting(input logic [SIDE_CFG_W-1:0] side,
                               input logic [WIN_CFG_W-1:0] win,
                               input logic [STRIDE_CFG_W-1:0] st,
                               input logic mode, input logic act);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    queue_write(REG_PLANE_SIDE, side);
    queue_write(REG_WINDOW_SIZE, {noise[6:4], win});
    queue_write(REG_STRIDE, {noise[2:0], st});
    queue_write(REG_POOL_MODE, {noise[5:0], mode});
    queue_write(REG_ACTIVATION, {noise[6:1], act});
  endtask

  task automatic queue_sample(input logic signed [DATA_WIDTH-1:0] smp);
    feed_entry_t e;
    e.is_cfg = 1'b0;
    e.idx = '0;
    e.data = '0;
    e.sample = smp;
    sample_feed.push_back(e);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_sample(input bit narrow);
    if (narrow) return DATA_WIDTH'($signed($urandom_range(0, 2)) - 1);
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return DATA_WIDTH'($signed($urandom_range(0, 4)) - 2);
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  task automatic queue_random_samples(input int n, input bit narrow);
    repeat (n) queue_sample(pick_sample(narrow));
    random_items += n;
  endtask

  // Random setting, then whole planes, at times a partial one; ws rows at full side.
  task automatic queue_random_phase();
    logic [SIDE_CFG_W-1:0]   side_v;
    logic [WIN_CFG_W-1:0]    win_v;
    logic [STRIDE_CFG_W-1:0] st_v;
    int side, ws, n;
    case ($urandom_range(0, 19))
      0:       side_v = SIDE_CFG_W'(64 + $urandom_range(0, 63));
      1:       side_v = '0;
      2, 3:    side_v = SIDE_CFG_W'($urandom_range(9, 16));
      default: side_v = SIDE_CFG_W'($urandom_range(1, 8));
    endcase
    side = side_in_use(side_v);
    case ($urandom_range(0, 9))
      0:       win_v = '0;
      1:       win_v = WIN_CFG_W'($urandom_range(9, 15));
      2:       win_v = WIN_CFG_W'($urandom_range(1, 8));
      default: win_v = WIN_CFG_W'($urandom_range(1, (side < MAX_WINDOW) ? side : MAX_WINDOW));
    endcase
    ws = window_in_use(win_v);
    case ($urandom_range(0, 9))
      0:       st_v = '0;
      1:       st_v = STRIDE_CFG_W'($urandom_range(9, 15));
      2, 3:    st_v = STRIDE_CFG_W'($urandom_range(1, 8));
      default: st_v = STRIDE_CFG_W'($urandom_range(1, 3));
    endcase
    queue_setting(side_v, win_v, st_v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 7) == 0) queue_write(REG_SPARE, CFG_DATA_W'($urandom));
    if (side == MAX_SIDE) begin
      n = MAX_SIDE * ws + $urandom_range(0, 127);
    end else begin
      n = $urandom_range(1, 2) * side * side;
      if ($urandom_range(0, 2) == 0) n += $urandom_range(0, side * side - 1);
    end
    queue_random_samples(n, $urandom_range(0, 4) == 0);
  endtask

  // Sample driver: presents feed entries, writes registers only once the block is idle.
  int gap_left = 0;
  int settle_cnt = 0;

  always @(posedge clk) begin : drive_proc
    logic nxt_in_valid;
    logic nxt_cfg_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      gap_left = 0;
      settle_cnt = 0;
    end else begin
      nxt_in_valid = in_ch.valid;
      nxt_cfg_valid = cfg_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_pooled_window(in_ch.sample);
        nxt_in_valid = 1'b0;
        if (sample_feed.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 18);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_register(cfg_ch.reg_index, cfg_ch.wr_data);
        nxt_cfg_valid = 1'b0;
      end
      if (pending_windows.size() == 0 && !in_ch.valid) settle_cnt++;
      else settle_cnt = 0;
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_feed.size() > 0) begin
          if (sample_feed[0].is_cfg) begin
            if (settle_cnt >= SETTLE_CYCLES) begin
              cfg_ch.reg_index <= sample_feed[0].idx;
              cfg_ch.wr_data <= sample_feed[0].data;
              nxt_cfg_valid = 1'b1;
              sample_feed.delete(0);
            end
          end else begin
            in_ch.sample <= sample_feed[0].sample;
            nxt_in_valid = 1'b1;
            sample_feed.delete(0);
          end
        end
      end
      in_ch.valid <= nxt_in_valid;
      cfg_ch.valid <= nxt_cfg_valid;
    end
  end

  task automatic compare_field(input string field, input logic [DATA_WIDTH-1:0] got,
                               input logic [DATA_WIDTH-1:0] want);
    if (got !== want) report_error($sformatf("%s got %h, want %h", field, got, want));
  endtask

  // Result monitor: random stall bursts on ready, every result checked in order.
  int stall_left = 0;

  always @(posedge clk) begin : collect_proc
    pool_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_windows.size() == 0) begin
          report_error("result arrived with no window pending");
        end else begin
          want = pending_windows.pop_front();
          compare_field("pooled_value", out_ch.pooled_value, want.pooled);
          compare_field("mask_value", out_ch.mask_value, want.mask);
          compare_field("out_row", out_ch.out_row, want.orow);
          compare_field("out_col", out_ch.out_col, want.ocol);
          compare_field("arg_row", out_ch.arg_row, want.arow);
          compare_field("arg_col", out_ch.arg_col, want.acol);
          compare_field("end_of_plane", out_ch.end_of_plane, want.eop);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sample_feed.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("pooling_window_forward_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wr_data = '0;

    // Directed: extremes and ties in max mode, with the end-of-plane flag.
    queue_setting(7'd2, 4'd2, 4'd2, MODE_MAX, ACT_NONE);
    queue_sample(16'sh8000);
    queue_sample(16'sh7fff);
    queue_sample(16'sh7fff);
    queue_sample(16'sh0000);
    // All equal: the maximum stays at the window's first element.
    repeat (4) queue_sample(16'sd5);
    // Mean of the most negative value, then cleared by ReLU.
    queue_setting(7'd2, 4'd2, 4'd1, MODE_MEAN, ACT_RELU);
    repeat (4) queue_sample(16'sh8000);
    // Mean truncates toward zero.
    queue_setting(7'd2, 4'd2, 4'd2, MODE_MEAN, ACT_NONE);
    repeat (3) queue_sample(-16'sd1);
    queue_sample(16'sd0);
    // Window larger than the plane gives nothing.
    queue_setting(7'd1, 4'd2, 4'd2, MODE_MAX, ACT_NONE);
    queue_sample(16'sd100);
    queue_sample(-16'sd100);
    // Zero side, window and stride are all taken as one.
    queue_setting(7'd0, 4'd0, 4'd0, MODE_MAX, ACT_RELU);
    queue_sample(-16'sd5);
    queue_sample(16'sd7);
    // An oversized window is clamped to the largest, still larger than the plane.
    queue_setting(7'd3, 4'd15, 4'd2, MODE_MAX, ACT_NONE);
    queue_sample(16'sd1);
    queue_sample(16'sd2);

    // Extreme settings: largest and smallest window, full and oversized side.
    queue_setting(7'd64, 4'd8, 4'd1, MODE_MAX, ACT_NONE);
    queue_random_samples(MAX_SIDE * 7 + 24, 1'b0);
    queue_setting(7'd8, 4'd8, 4'd8, MODE_MEAN, ACT_RELU);
    queue_random_samples(64, 1'b0);
    queue_setting(7'd64, 4'd1, 4'd1, MODE_MEAN, ACT_NONE);
    queue_random_samples(128, 1'b0);
    queue_setting(7'd127, 4'd3, 4'd8, MODE_MAX, ACT_RELU);
    queue_random_samples(MAX_SIDE * 3 + 16, 1'b1);

    while (random_items < RANDOM_ITEMS) queue_random_phase();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_feed.size() > 0 || pending_windows.size() > 0 || in_ch.valid ||
           cfg_ch.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_windows.size() == 0)
      $display("pooling_window_forward_unit regression: pass");
    else
      $display("pooling_window_forward_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/pwf_pkg.sv
rtl/core/pwf_ifs.sv
rtl/core/pwf_ram.sv
rtl/core/pwf_divider.sv
rtl/core/pwf_scan.sv
rtl/core/pooling_window_forward_unit.sv
bench/pooling_window_forward_unit_test.sv
